>>> src/spe_pkg.sv
// ============================================================================
// spe_pkg
// Shared types and constants for the swap permutation enumerator.
// ============================================================================
package spe_pkg;

    localparam int VALUE_W    = 32;
    localparam int POS_W      = 4;
    localparam int LEN_W      = 5;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CNT_W      = 5;

    localparam logic              OP_LOAD      = 1'b0;
    localparam logic              OP_NEXT      = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_ARRAY_LENGTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_START_POSITION = 1'b1;

    typedef struct packed {
        logic                      opcode;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] element_value;
    } req_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] out_value;
        logic [POS_W-1:0]          out_position;
        logic                      last;
        logic                      done_res;
    } rsp_item_t;

    // Control of the index pair stack.
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } stack_ctl_t;

endpackage

>>> src/spe_ram.sv
// ============================================================================
// spe_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
module spe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/spe_stack.sv
// ============================================================================
// spe_stack
// Bounded stack of (level, swap) index pairs with a pair count.
// ============================================================================
module spe_stack #(
    parameter int DEPTH = 16,
    parameter int W     = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  spe_pkg::stack_ctl_t ctl,
    input  logic [W-1:0]        push_data,
    output logic [W-1:0]        top_data,
    output logic                empty,
    output logic                full
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]     entry_reg [DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] count_dec;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign count_dec = count_reg - CNT_W'(1);
    assign top_data  = entry_reg[count_dec[PTR_W-1:0]];

    always_comb
    begin
        count_next = count_reg;
        if (ctl.clear)
        begin
            count_next = '0;
        end
        else if (ctl.push && !full)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctl.pop && !empty)
        begin
            count_next = count_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!ctl.clear && ctl.push && !full)
        begin
            entry_reg[count_reg[PTR_W-1:0]] <= push_data;
        end
    end

endmodule

>>> src/swap_permutation_enumerator.sv
// ============================================================================
// swap_permutation_enumerator
// Depth-first swap enumeration of the array tail, one permutation or a done result per next request.
// ============================================================================
// A load leaves the block idle; the block stalls new requests until one is finished.
// A next request undoes swaps through ST_POP and applies swaps through ST_DESC;
// each swap passes ST_SRA, ST_SRB, ST_SWA and ST_SWB (four accesses on the single
// element RAM port pair), and each emitted element passes ST_ERD and ST_ELD. A done
// result passes ST_DONE, after the undone swaps when it ends the run. Result stalls hold ST_ELD and ST_DONE.
// Reset clears the stack, the sequencer and the flags; element data is
// undefined until loaded. array_length resets to 8, start_position to 0.
module swap_permutation_enumerator #(
    parameter int MAX_LEN    = 16,
    parameter int ELEM_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  spe_pkg::req_item_t               req_item,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output spe_pkg::rsp_item_t               rsp_item,
    input  logic                             cfg_we,
    input  logic [spe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [spe_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW    = spe_pkg::CNT_W;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_POP  = 4'd1;
    localparam logic [3:0] ST_SRA  = 4'd2;
    localparam logic [3:0] ST_SRB  = 4'd3;
    localparam logic [3:0] ST_SWA  = 4'd4;
    localparam logic [3:0] ST_SWB  = 4'd5;
    localparam logic [3:0] ST_DESC = 4'd6;
    localparam logic [3:0] ST_ERD  = 4'd7;
    localparam logic [3:0] ST_ELD  = 4'd8;
    localparam logic [3:0] ST_DONE = 4'd9;

    logic [3:0]                   state_reg, state_next;
    logic [spe_pkg::LEN_W-1:0]    length_reg, length_next;
    logic [spe_pkg::POS_W-1:0]    start_reg, start_next;
    logic                         started_reg, started_next;
    logic                         finished_reg, finished_next;
    logic [CW-1:0]                level_reg, level_next;
    logic [CW-1:0]                swap_reg, swap_next;
    logic [CW-1:0]                a_reg, a_next;
    logic [CW-1:0]                b_reg, b_next;
    logic [CW-1:0]                k_reg, k_next;
    logic                         ret_pop_reg, ret_pop_next;
    logic [ELEM_WIDTH-1:0]        tmp_reg, tmp_next;
    logic                         rsp_valid_reg, rsp_valid_next;
    spe_pkg::rsp_item_t           rsp_item_reg, rsp_item_next;

    logic [CW-1:0]                n_len;
    logic [CW-1:0]                level_inc;
    logic [CW-1:0]                b_inc;
    logic                         rsp_free;
    logic                         req_fire;
    logic signed [31:0]           elem_ext;

    logic                         ram_we;
    logic [IDX_W-1:0]             ram_waddr;
    logic [ELEM_WIDTH-1:0]        ram_wdata;
    logic                         ram_re;
    logic [IDX_W-1:0]             ram_raddr;
    logic [ELEM_WIDTH-1:0]        ram_rdata;

    spe_pkg::stack_ctl_t          stk_ctl;
    logic [2*IDX_W-1:0]           stk_push_data;
    logic [2*IDX_W-1:0]           stk_top;
    logic                         stk_empty;
    logic                         stk_full;

    spe_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (MAX_LEN)
    ) u_elem_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    spe_stack #(
        .DEPTH (MAX_LEN),
        .W     (2 * IDX_W)
    ) u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (stk_ctl),
        .push_data (stk_push_data),
        .top_data  (stk_top),
        .empty     (stk_empty),
        .full      (stk_full)
    );

    // Zero length acts as one; anything above the capacity acts as the capacity.
    always_comb
    begin
        if (length_reg == '0)
        begin
            n_len = CW'(1);
        end
        else if (32'(length_reg) > MAX_LEN)
        begin
            n_len = CW'(MAX_LEN);
        end
        else
        begin
            n_len = CW'(length_reg);
        end
    end

    assign level_inc = level_reg + CW'(1);
    assign b_inc     = b_reg + CW'(1);
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign elem_ext  = 32'(signed'(ram_rdata));
    assign stk_push_data = {level_reg[IDX_W-1:0], swap_reg[IDX_W-1:0]};

    always_comb
    begin
        state_next     = state_reg;
        length_next    = length_reg;
        start_next     = start_reg;
        started_next   = started_reg;
        finished_next  = finished_reg;
        level_next     = level_reg;
        swap_next      = swap_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        k_next         = k_reg;
        ret_pop_next   = ret_pop_reg;
        tmp_next       = tmp_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_item_next  = rsp_item_reg;
        ram_we         = 1'b0;
        ram_waddr      = a_reg[IDX_W-1:0];
        ram_wdata      = ram_rdata;
        ram_re         = 1'b0;
        ram_raddr      = a_reg[IDX_W-1:0];
        stk_ctl        = '0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req_item.opcode == spe_pkg::OP_LOAD)
                    begin
                        ram_we        = (32'(req_item.position) < MAX_LEN);
                        ram_waddr     = IDX_W'(req_item.position);
                        ram_wdata     = ELEM_WIDTH'({32'b0, req_item.element_value});
                        stk_ctl.clear = 1'b1;
                        started_next  = 1'b0;
                        finished_next = 1'b0;
                    end
                    else if (finished_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (!started_reg)
                    begin
                        started_next = 1'b1;
                        level_next   = CW'(start_reg);
                        swap_next    = CW'(start_reg);
                        state_next   = ST_DESC;
                    end
                    else
                    begin
                        state_next = ST_POP;
                    end
                end
            end
            ST_POP:
            begin
                if (stk_empty)
                begin
                    stk_ctl.clear = 1'b1;
                    finished_next = 1'b1;
                    state_next    = ST_DONE;
                end
                else
                begin
                    stk_ctl.pop  = 1'b1;
                    a_next       = CW'(stk_top[2*IDX_W-1:IDX_W]);
                    b_next       = CW'(stk_top[IDX_W-1:0]);
                    ret_pop_next = 1'b1;
                    state_next   = ST_SRA;
                end
            end
            ST_SRA:
            begin
                ram_re     = 1'b1;
                ram_raddr  = a_reg[IDX_W-1:0];
                state_next = ST_SRB;
            end
            ST_SRB:
            begin
                tmp_next   = ram_rdata;
                ram_re     = 1'b1;
                ram_raddr  = b_reg[IDX_W-1:0];
                state_next = ST_SWA;
            end
            ST_SWA:
            begin
                ram_we     = 1'b1;
                ram_waddr  = a_reg[IDX_W-1:0];
                ram_wdata  = ram_rdata;
                state_next = ST_SWB;
            end
            ST_SWB:
            begin
                ram_we    = 1'b1;
                ram_waddr = b_reg[IDX_W-1:0];
                ram_wdata = tmp_reg;
                if (ret_pop_reg)
                begin
                    // An undone level with no swap partner left unwinds further.
                    if (b_inc >= n_len)
                    begin
                        state_next = ST_POP;
                    end
                    else
                    begin
                        level_next = a_reg;
                        swap_next  = b_inc;
                        state_next = ST_DESC;
                    end
                end
                else
                begin
                    level_next = level_inc;
                    swap_next  = level_inc;
                    state_next = ST_DESC;
                end
            end
            ST_DESC:
            begin
                if (level_inc < n_len)
                begin
                    stk_ctl.push = 1'b1;
                    a_next       = level_reg;
                    b_next       = swap_reg;
                    ret_pop_next = 1'b0;
                    state_next   = ST_SRA;
                end
                else
                begin
                    k_next     = '0;
                    state_next = ST_ERD;
                end
            end
            ST_ERD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = k_reg[IDX_W-1:0];
                state_next = ST_ELD;
            end
            ST_ELD:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next             = 1'b1;
                    rsp_item_next.out_value    = elem_ext;
                    rsp_item_next.out_position = spe_pkg::POS_W'(k_reg);
                    rsp_item_next.last         = (k_reg + CW'(1) == n_len);
                    rsp_item_next.done_res     = 1'b0;
                    k_next                     = k_reg + CW'(1);
                    state_next = (k_reg + CW'(1) == n_len) ? ST_IDLE : ST_ERD;
                end
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next             = 1'b1;
                    rsp_item_next.out_value    = '0;
                    rsp_item_next.out_position = '0;
                    rsp_item_next.last         = 1'b1;
                    rsp_item_next.done_res     = 1'b1;
                    state_next                 = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Register writes must come only while idle (unenforced) and restart the enumeration.
        if (cfg_we)
        begin
            if (cfg_index == spe_pkg::REG_ARRAY_LENGTH)
            begin
                length_next = cfg_data[spe_pkg::LEN_W-1:0];
            end
            else
            begin
                start_next = cfg_data[spe_pkg::POS_W-1:0];
            end
            stk_ctl.clear = 1'b1;
            started_next  = 1'b0;
            finished_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            length_reg    <= spe_pkg::LEN_W'(8);
            start_reg     <= '0;
            started_reg   <= 1'b0;
            finished_reg  <= 1'b0;
            level_reg     <= '0;
            swap_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            length_reg    <= length_next;
            start_reg     <= start_next;
            started_reg   <= started_next;
            finished_reg  <= finished_next;
            level_reg     <= level_next;
            swap_reg      <= swap_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        k_reg        <= k_next;
        ret_pop_reg  <= ret_pop_next;
        tmp_reg      <= tmp_next;
        rsp_item_reg <= rsp_item_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    // Before the first request of a run and after the run ends, no pair is held.
    a_stack_empty_unstarted: assert property (@(posedge clk) disable iff (!rst_n)
        !started_reg |-> stk_empty)
        else $error("stack holds pairs before the run started");

    a_stack_empty_finished: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |-> stk_empty)
        else $error("stack holds pairs after the run finished");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        stk_ctl.push |-> !stk_full)
        else $error("push into a full index stack");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_item.done_res) |-> rsp_item.last)
        else $error("done result without last flag");

endmodule

>>> tb/sv/swap_permutation_enumerator_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// swap_permutation_enumerator_tb
// Self-checking bench for the swap permutation enumerator. Requests come from
// a queue and are sent in bursts, while the result side stalls in changing
// patterns. A behavioral copy of the depth-first swap walk predicts every
// result, and a monitor compares each result field by field.
// ============================================================================
module swap_permutation_enumerator_tb;

    localparam int RANDOM_ITEMS = 130;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int SETTLE       = 40;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           req_valid = 1'b0;
    logic                           req_stall;
    spe_pkg::req_item_t             req_item  = '0;
    logic                           rsp_valid;
    logic                           rsp_stall = 1'b0;
    spe_pkg::rsp_item_t             rsp_item;
    logic                           cfg_we    = 1'b0;
    logic [spe_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [spe_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    swap_permutation_enumerator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Behavioral copy of the array, the index pair stack and the walk state.
    logic signed [spe_pkg::VALUE_W-1:0] perm_array [16];
    logic [spe_pkg::POS_W-1:0]          pair_stack [32];
    int                                 pair_depth;
    int                                 walk_level;
    int                                 walk_swap;
    bit                                 walk_started;
    bit                                 walk_done;
    logic [spe_pkg::LEN_W-1:0]          length_reg = 5'd8;
    logic [spe_pkg::POS_W-1:0]          start_reg  = '0;

    spe_pkg::req_item_t request_q [$];
    spe_pkg::rsp_item_t perm_results_q [$];

    int mismatch_count = 0;
    int cycle_count    = 0;

    function automatic int used_length(input logic [spe_pkg::LEN_W-1:0] len);
        if (len == 0)
            return 1;
        if (len > 16)
            return 16;
        return int'(len);
    endfunction

    function automatic void restart_walk();
        pair_depth   = 0;
        walk_level   = 0;
        walk_swap    = 0;
        walk_started = 1'b0;
        walk_done    = 1'b0;
    endfunction

    function automatic void swap_pair(input int a, input int b);
        logic signed [spe_pkg::VALUE_W-1:0] t;
        t             = perm_array[a];
        perm_array[a] = perm_array[b];
        perm_array[b] = t;
    endfunction

    function automatic void push_pair_index(input int v);
        if (pair_depth < 32)
        begin
            pair_stack[pair_depth] = v[spe_pkg::POS_W-1:0];
            pair_depth++;
        end
    endfunction

    function automatic int pop_pair_index();
        if (pair_depth == 0)
            return 0;
        pair_depth--;
        return int'(pair_stack[pair_depth]);
    endfunction

    function automatic void add_done_result();
        spe_pkg::rsp_item_t r;
        r.out_value    = '0;
        r.out_position = '0;
        r.last         = 1'b1;
        r.done_res     = 1'b1;
        perm_results_q.push_back(r);
    endfunction

    // Advances the walk for one accepted request and queues the results it yields.
    function automatic void advance_permutation(input spe_pkg::req_item_t it);
        int                 n;
        int                 lv;
        int                 sw;
        spe_pkg::rsp_item_t r;
        n = used_length(length_reg);
        if (it.opcode == spe_pkg::OP_LOAD)
        begin
            perm_array[it.position] = it.element_value;
            restart_walk();
            return;
        end
        if (walk_done)
        begin
            add_done_result();
            return;
        end
        if (!walk_started)
        begin
            walk_started = 1'b1;
            walk_level   = int'(start_reg);
            walk_swap    = int'(start_reg);
        end
        else
        begin
            // Undo swaps until a level still has another candidate.
            do
            begin
                if (pair_depth < 2)
                begin
                    pair_depth = 0;
                    walk_done  = 1'b1;
                    add_done_result();
                    return;
                end
                sw = pop_pair_index();
                lv = pop_pair_index();
                swap_pair(lv, sw);
                sw++;
            end
            while (sw > n - 1);
            walk_level = lv;
            walk_swap  = sw;
        end
        while (walk_level < n - 1)
        begin
            push_pair_index(walk_level);
            push_pair_index(walk_swap);
            swap_pair(walk_level, walk_swap);
            walk_level++;
            walk_swap = walk_level;
        end
        for (int k = 0; k < n; k++)
        begin
            r.out_value    = perm_array[k];
            r.out_position = k[spe_pkg::POS_W-1:0];
            r.last         = (k == n - 1);
            r.done_res     = 1'b0;
            perm_results_q.push_back(r);
        end
    endfunction

    function automatic logic signed [spe_pkg::VALUE_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    function automatic spe_pkg::req_item_t load_req(
        input int                                 pos,
        input logic signed [spe_pkg::VALUE_W-1:0] v
    );
        spe_pkg::req_item_t it;
        it.opcode        = spe_pkg::OP_LOAD;
        it.position      = pos[spe_pkg::POS_W-1:0];
        it.element_value = v;
        return it;
    endfunction

    // The position and value of a next request are don't-care; fill them randomly.
    function automatic spe_pkg::req_item_t next_req();
        spe_pkg::req_item_t it;
        it.opcode        = spe_pkg::OP_NEXT;
        it.position      = spe_pkg::POS_W'($urandom_range(0, 15));
        it.element_value = $urandom;
        return it;
    endfunction

    // Request driver: bursts of random length with random gaps between them.
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_item  <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
                advance_permutation(req_item);
            if (!req_valid || !req_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (request_q.size() > 0)
                begin
                    req_valid <= 1'b1;
                    req_item  <= request_q.pop_front();
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        if ($urandom_range(0, 4) == 0)
                        begin
                            burst_left = $urandom_range(20, 60);
                            gap_left   = 0;
                        end
                        else
                        begin
                            burst_left = $urandom_range(1, 8);
                            gap_left   = $urandom_range(0, 6);
                        end
                    end
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Result monitor with a stall pattern that switches between modes.
    int stall_mode  = 0;
    int mode_left   = 100;
    int stall_phase = 0;

    always @(posedge clk or negedge rst_n)
    begin
        spe_pkg::rsp_item_t want;
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (perm_results_q.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("unexpected result: value %0d pos %0d last %0b done %0b",
                                 rsp_item.out_value, rsp_item.out_position,
                                 rsp_item.last, rsp_item.done_res);
                    mismatch_count++;
                end
                else
                begin
                    want = perm_results_q.pop_front();
                    if (rsp_item.out_value !== want.out_value
                        || rsp_item.out_position !== want.out_position
                        || rsp_item.last !== want.last
                        || rsp_item.done_res !== want.done_res)
                    begin
                        if (mismatch_count < 10)
                        begin
                            $write("mismatch: expected value %0d pos %0d last %0b done %0b,",
                                   want.out_value, want.out_position, want.last,
                                   want.done_res);
                            $display(" got value %0d pos %0d last %0b done %0b",
                                     rsp_item.out_value, rsp_item.out_position,
                                     rsp_item.last, rsp_item.done_res);
                        end
                        mismatch_count++;
                    end
                end
            end
            mode_left--;
            if (mode_left <= 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(64, 256);
            end
            stall_phase = (stall_phase + 1) % 5;
            case (stall_mode)
                0:       rsp_stall <= 1'b0;
                1:       rsp_stall <= ($urandom_range(0, 2) == 0);
                default: rsp_stall <= (stall_phase < 2);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("swap_permutation_enumerator_tb failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [spe_pkg::CFG_IDX_W-1:0] idx, input int data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data[spe_pkg::CFG_DATA_W-1:0];
        if (idx == spe_pkg::REG_ARRAY_LENGTH)
            length_reg = data[spe_pkg::LEN_W-1:0];
        else
            start_reg = data[spe_pkg::POS_W-1:0];
        restart_walk();
    endtask

    task automatic set_walk_config(input int len, input int start);
        if ($urandom_range(0, 1))
        begin
            write_reg(spe_pkg::REG_ARRAY_LENGTH, len);
            write_reg(spe_pkg::REG_START_POSITION, start);
        end
        else
        begin
            write_reg(spe_pkg::REG_START_POSITION, start);
            write_reg(spe_pkg::REG_ARRAY_LENGTH, len);
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Waits until every request is taken and every result is in, then lets a
    // load that yields no result finish before the next register write.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (request_q.size() != 0 || req_valid || perm_results_q.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        int random_count;
        int len_val;
        int start_val;
        int n;
        int span;
        int perms;
        int next_count;
        restart_walk();
        random_count = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Every element is loaded first so that no unwritten entry is ever read.
        request_q.push_back(load_req(0, 32'sh8000_0000));
        request_q.push_back(load_req(1, 32'sh7FFF_FFFF));
        request_q.push_back(load_req(2, 0));
        request_q.push_back(load_req(3, -1));
        request_q.push_back(load_req(4, 1));
        request_q.push_back(load_req(5, 32'sh5555_5555));
        request_q.push_back(load_req(6, 32'shAAAA_AAAA));
        for (int p = 7; p < 16; p++)
            request_q.push_back(load_req(p, random_value()));
        request_q.push_back(next_req());
        wait_drained();

        // A length of zero acts as one: one pass over the array, then done repeats.
        set_walk_config(0, 0);
        repeat (3) request_q.push_back(next_req());
        wait_drained();

        // Length above the array size with the start on the last index.
        set_walk_config(31, 15);
        repeat (2) request_q.push_back(next_req());
        wait_drained();

        // A load in the middle of a walk restarts it from the present order.
        set_walk_config(3, 1);
        request_q.push_back(next_req());
        request_q.push_back(load_req(15, random_value()));
        request_q.push_back(next_req());
        request_q.push_back(next_req());
        wait_drained();

        while (random_count < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 19))
                0:       len_val = 0;
                1:       len_val = 16;
                2:       len_val = 31;
                3:       len_val = $urandom_range(17, 30);
                4, 5:    len_val = $urandom_range(5, 15);
                default: len_val = $urandom_range(1, 4);
            endcase
            n = used_length(len_val[spe_pkg::LEN_W-1:0]);
            case ($urandom_range(0, 5))
                0:       start_val = $urandom_range(0, 15);
                1:       start_val = n - 1;
                default: start_val = $urandom_range((n > 4) ? n - 4 : 0, n - 1);
            endcase
            set_walk_config(len_val, start_val);

            span = n - start_val;
            if (span <= 1)
                perms = 1;
            else if (span <= 4)
            begin
                perms = 1;
                for (int f = 2; f <= span; f++)
                    perms *= f;
            end
            else
                perms = $urandom_range(3, 8);
            next_count = (span <= 4) ? perms + $urandom_range(1, 2) : perms;

            for (int i = 0; i < next_count; i++)
            begin
                if ($urandom_range(0, 11) == 0)
                begin
                    request_q.push_back(load_req($urandom_range(0, 15), random_value()));
                    random_count++;
                end
                request_q.push_back(next_req());
                random_count++;
            end
            wait_drained();
        end

        if (mismatch_count == 0 && perm_results_q.size() == 0)
            $display("swap_permutation_enumerator_tb passed");
        else
            $display("swap_permutation_enumerator_tb failed");
        $finish;
    end

endmodule
